### rtl/core/mqee_pkg.sv
// Package for the ephemeral-evicting mailbox queue.
// Holds request and response payload types, status and opcode codes,
// controller state and command types. No dependencies.
`timescale 1ns / 1ps

package mqee_pkg;

   // Default depth of the queue in entries.
   localparam int MAX_ENTRIES_DEF = 16;

   // Width of the capacity register and its largest value.
   localparam int CAP_W       = 5;
   localparam int CAP_REG_MAX = (2 ** CAP_W) - 1;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Request opcodes.
   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_POP     = 2'd1;
   localparam logic [1:0] OP_REQUEUE = 2'd2;

   // Response status codes.
   typedef enum logic [2:0] {
      RS_ACCEPTED = 3'd0,
      RS_EVICTED  = 3'd1,
      RS_FULL     = 3'd2,
      RS_INVALID  = 3'd3,
      RS_EMPTY    = 3'd4,
      RS_REFUSED  = 3'd5
   } status_type;

   // One request as it arrives at the block.
   typedef struct packed {
      logic [1:0]  opcode;
      logic        type_present;
      logic        durable;
      logic [31:0] sequence_req;
      logic [31:0] payload;
   } req_type;

   // One response as it leaves the block.
   typedef struct packed {
      logic [2:0]  status;
      logic        item_valid;
      logic        item_durable;
      logic [31:0] item_sequence;
      logic [31:0] item_payload;
      logic [4:0]  fill_level;
      logic [31:0] dropped_ephemeral_total;
      logic [31:0] rejected_durable_total;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EXEC
   } state_type;

   // Queue operations that the datapath carries out.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH,
      ACT_EVICT_PUSH,
      ACT_POP,
      ACT_REQUEUE
   } act_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       search;
      logic       exec;
      act_type    act;
      status_type status;
      logic       inc_drop;
      logic       inc_reject;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic       req_durable;
      logic       event_ok;
      logic       at_cap;
      logic       over_cap;
      logic       empty;
      logic       evict_found;
   } dp_stat_type;

   // Saturating increment of a 32-bit counter.
   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      return (value == '1) ? value : value + 32'd1;
   endfunction

endpackage

### rtl/core/mqee_ctrl.sv
// Controller state machine of the mailbox queue.
// Sequences capture, eviction search and execution; decides each request.
// Depends on mqee_pkg.
`timescale 1ns / 1ps

module mqee_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   input  mqee_pkg::dp_stat_type stat,
   output mqee_pkg::cmd_type    cmd
);
   import mqee_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;
   logic      strobe_in;

   // State and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      strobe_in      = 1'b0;
      cmd            = '0;
      cmd.act        = ACT_NONE;
      cmd.status     = RS_INVALID;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec  = 1'b1;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            unique case (stat.opcode)
               OP_PUSH: begin
                  if (!stat.event_ok) begin
                     cmd.status = RS_INVALID;
                  end else if (!stat.at_cap) begin
                     cmd.act    = ACT_PUSH;
                     cmd.status = RS_ACCEPTED;
                  end else if (!stat.req_durable) begin
                     cmd.status   = RS_FULL;
                     cmd.inc_drop = 1'b1;
                  end else if (stat.evict_found) begin
                     cmd.act      = ACT_EVICT_PUSH;
                     cmd.status   = RS_EVICTED;
                     cmd.inc_drop = 1'b1;
                  end else begin
                     cmd.status     = RS_FULL;
                     cmd.inc_reject = 1'b1;
                  end
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.status = RS_EMPTY;
                  end else begin
                     cmd.act    = ACT_POP;
                     cmd.status = RS_ACCEPTED;
                  end
               end
               OP_REQUEUE: begin
                  if (!stat.event_ok) begin
                     cmd.status = RS_INVALID;
                  end else if (stat.over_cap) begin
                     cmd.status = RS_REFUSED;
                  end else begin
                     cmd.act    = ACT_REQUEUE;
                     cmd.status = RS_ACCEPTED;
                  end
               end
               default: begin
                  cmd.status = RS_INVALID;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

### rtl/core/mqee_dp.sv
// Datapath of the mailbox queue: shift-cell entry store, capacity register,
// eviction search, saturating counters and the response register.
// Depends on mqee_pkg.
`timescale 1ns / 1ps

module mqee_dp #(
   parameter int MAX_ENTRIES = mqee_pkg::MAX_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mqee_pkg::req_type             req_data,
   input  logic                          csr_write_en,
   input  logic [mqee_pkg::CAP_W-1:0]    csr_write_data,
   input  mqee_pkg::cmd_type             cmd,
   output mqee_pkg::dp_stat_type         stat,
   output mqee_pkg::rsp_type             rsp_data
);
   import mqee_pkg::*;

   // The capacity register limits the fill, with one slot more for a requeue, so cells past that are never used.
   localparam int CAP_MAX    = (MAX_ENTRIES < CAP_REG_MAX) ? MAX_ENTRIES : CAP_REG_MAX;
   localparam int SLOT_COUNT = CAP_MAX + 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   typedef struct packed {
      logic        durable;
      logic [31:0] seq;
      logic [31:0] payload;
   } entry_type;

   entry_type              cells_ff [SLOT_COUNT];
   entry_type              cells_in [SLOT_COUNT];
   entry_type              nxt_cell [SLOT_COUNT];
   entry_type              prv_cell [SLOT_COUNT];
   entry_type              new_entry;
   req_type                req_ff;
   logic [CAP_W-1:0]       capacity_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [31:0]            dropped_ff;
   logic [31:0]            dropped_in;
   logic [31:0]            rejected_ff;
   logic [31:0]            rejected_in;
   logic [SLOT_COUNT-1:0]  eph_mask;
   logic [SLOT_COUNT-1:0]  shift_mask_ff;
   logic                   found_ff;
   logic [CAP_W-1:0]       cap_lim;
   logic [CNT_W-1:0]       cap_cnt;
   logic                   seq_zero;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   // Capacity register and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Effective capacity: zero acts as one, values past the depth are clamped.
   always_comb begin
      if (capacity_ff > CAP_W'(CAP_MAX)) begin
         cap_lim = CAP_W'(CAP_MAX);
      end else begin
         cap_lim = capacity_ff;
      end
      if (cap_lim == '0) begin
         cap_lim = CAP_W'(1);
      end
      cap_cnt = CNT_W'(cap_lim);
   end

   // Occupied ephemeral cells; x | -x marks the oldest one and all after it.
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         eph_mask[i] = !cells_ff[i].durable && (CNT_W'(i) < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         shift_mask_ff <= eph_mask | (~eph_mask + SLOT_COUNT'(1));
         found_ff      <= |eph_mask;
      end
   end

   // Status toward the controller.
   assign seq_zero = (req_ff.sequence_req == '0);
   always_comb begin
      stat.opcode      = req_ff.opcode;
      stat.req_durable = req_ff.durable;
      stat.event_ok    = req_ff.type_present && (req_ff.durable != seq_zero);
      stat.at_cap      = (count_ff >= cap_cnt);
      stat.over_cap    = (count_ff > cap_cnt) || (count_ff >= CNT_W'(SLOT_COUNT));
      stat.empty       = (count_ff == '0);
      stat.evict_found = found_ff;
   end

   // Neighbor views of the cells for shifting toward the front or back.
   assign new_entry = '{durable: req_ff.durable, seq: req_ff.sequence_req,
                        payload: req_ff.payload};
   always_comb begin
      for (int i = 0; i < SLOT_COUNT - 1; i++) begin
         nxt_cell[i] = cells_ff[i+1];
      end
      nxt_cell[SLOT_COUNT-1] = cells_ff[SLOT_COUNT-1];
      prv_cell[0] = new_entry;
      for (int i = 1; i < SLOT_COUNT; i++) begin
         prv_cell[i] = cells_ff[i-1];
      end
   end

   // Per-cell update for the selected operation.
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (cmd.exec) begin
         case (cmd.act)
            ACT_PUSH: begin
               count_in = count_ff + CNT_W'(1);
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (CNT_W'(i) == count_ff) begin
                     cells_in[i] = new_entry;
                  end
               end
            end
            ACT_EVICT_PUSH: begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (CNT_W'(i + 1) == count_ff) begin
                     cells_in[i] = new_entry;
                  end else if (shift_mask_ff[i]) begin
                     cells_in[i] = nxt_cell[i];
                  end
               end
            end
            ACT_POP: begin
               count_in = count_ff - CNT_W'(1);
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  cells_in[i] = nxt_cell[i];
               end
            end
            ACT_REQUEUE: begin
               count_in = count_ff + CNT_W'(1);
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  cells_in[i] = prv_cell[i];
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   // Fill count and saturating drop and reject counters.
   always_comb begin
      dropped_in  = dropped_ff;
      rejected_in = rejected_ff;
      if (cmd.exec && cmd.inc_drop) begin
         dropped_in = sat_inc(dropped_ff);
      end
      if (cmd.exec && cmd.inc_reject) begin
         rejected_in = sat_inc(rejected_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dropped_ff  <= '0;
         rejected_ff <= '0;
      end else begin
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         rejected_ff <= rejected_in;
      end
   end

   // Response register, loaded when a request executes.
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = cmd.status;
      if (cmd.act == ACT_POP) begin
         rsp_in.item_valid    = 1'b1;
         rsp_in.item_durable  = cells_ff[0].durable;
         rsp_in.item_sequence = cells_ff[0].seq;
         rsp_in.item_payload  = cells_ff[0].payload;
      end
      rsp_in.fill_level              = 5'(count_in);
      rsp_in.dropped_ephemeral_total = dropped_in;
      rsp_in.rejected_durable_total  = rejected_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/core/mailbox_queue_ephemeral_evict.sv
// Each request passes the accepting edge, then a search state in which the
// datapath marks the oldest queued ephemeral entry, then an execute state in
// which the controller decides and the shift cells move. The response shows on
// rsp_data with rsp_strobe high for exactly one cycle; both are registered as
// the execute state ends, and busy is already low then, so the next request
// can be taken while the response is out. No new request is accepted while
// busy is high. The receiver cannot stall: it must take each response in its
// one strobe cycle. Capacity may be written only while busy is low and no
// response is pending.
//
// Top level of the mailbox queue with ephemeral eviction.
// Depends on mqee_pkg, mqee_ctrl and mqee_dp.
`timescale 1ns / 1ps

module mailbox_queue_ephemeral_evict #(
   parameter int MAX_ENTRIES = mqee_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mqee_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output mqee_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_en,
   input  logic [mqee_pkg::CAP_W-1:0] csr_write_data
);
   import mqee_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   // Controller.
   mqee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath.
   mqee_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_data       (rsp_data)
   );

endmodule

### tb/tb.sv
// Self-checking testbench for the ephemeral-evicting mailbox queue.
// It drives directed and random requests against a queue predictor in several capacity phases.
// Depends on mqee_pkg and mailbox_queue_ephemeral_evict.
`timescale 1ns / 1ps

module tb;
   import mqee_pkg::*;

   localparam int DEPTH = MAX_ENTRIES_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PER_PHASE = 163;
   localparam logic [CAP_W-1:0] PHASE_CAPS [10] = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0,
                                                    5'd5, 5'd16, 5'd3, 5'd12, 5'd8};

   typedef struct {
      logic        durable;
      logic [31:0] sequence_num;
      logic [31:0] payload;
   } entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_write_en = 1'b0;
   logic [CAP_W-1:0] csr_write_data = '0;

   // Predicted mailbox contents, front at index 0, and its counters.
   entry_type        held[$];
   logic [CAP_W-1:0] model_capacity = CAP_RESET;
   logic [31:0]      model_dropped = '0;
   logic [31:0]      model_rejected = '0;

   req_type pending[$];
   rsp_type expected[$];
   rsp_type oldest;
   int      errors = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      idle_cycles = 0;

   mailbox_queue_ephemeral_evict uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] bump_saturated(logic [31:0] count);
      return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
   endfunction

   // Apply one accepted request to the predicted mailbox and return its response.
   function automatic rsp_type mailbox_step(req_type rq);
      rsp_type   rs;
      entry_type ent;
      int        lim;
      int        pos;
      int        i;
      logic      well_formed;
      rs = '0;
      rs.status = RS_INVALID;
      if (model_capacity == 0) lim = 1;
      else if (model_capacity > DEPTH) lim = DEPTH;
      else lim = int'(model_capacity);
      well_formed = rq.type_present &&
                    (rq.durable ? (rq.sequence_req != 0) : (rq.sequence_req == 0));
      ent.durable = rq.durable;
      ent.sequence_num = rq.sequence_req;
      ent.payload = rq.payload;
      case (rq.opcode)
         OP_PUSH: begin
            if (well_formed) begin
               rs.status = RS_ACCEPTED;
               if (held.size() >= lim) begin
                  // A durable push looks for the oldest ephemeral entry to evict.
                  pos = -1;
                  if (rq.durable) begin
                     for (i = held.size() - 1; i >= 0; i--) begin
                        if (!held[i].durable) pos = i;
                     end
                  end
                  if (!rq.durable) begin
                     model_dropped = bump_saturated(model_dropped);
                     rs.status = RS_FULL;
                  end else if (pos < 0) begin
                     model_rejected = bump_saturated(model_rejected);
                     rs.status = RS_FULL;
                  end else begin
                     held.delete(pos);
                     model_dropped = bump_saturated(model_dropped);
                     rs.status = RS_EVICTED;
                  end
               end
               if (rs.status != RS_FULL) held.insert(held.size(), ent);
            end
         end
         OP_POP: begin
            if (held.size() == 0) begin
               rs.status = RS_EMPTY;
            end else begin
               ent = held[0];
               held.delete(0);
               rs.status = RS_ACCEPTED;
               rs.item_valid = 1'b1;
               rs.item_durable = ent.durable;
               rs.item_sequence = ent.sequence_num;
               rs.item_payload = ent.payload;
            end
         end
         OP_REQUEUE: begin
            // A requeue may take one slot beyond the capacity.
            if (well_formed) begin
               if (held.size() > lim || held.size() >= DEPTH + 1) begin
                  rs.status = RS_REFUSED;
               end else begin
                  held.insert(0, ent);
                  rs.status = RS_ACCEPTED;
               end
            end
         end
         default: ;
      endcase
      rs.fill_level = 5'(held.size());
      rs.dropped_ephemeral_total = model_dropped;
      rs.rejected_durable_total = model_rejected;
      return rs;
   endfunction

   // Mostly well-formed events with random content, plus some malformed ones.
   function automatic req_type random_request(int push_weight);
      req_type rq;
      int      pick;
      rq.payload = $urandom;
      rq.type_present = 1'b1;
      rq.durable = 1'($urandom_range(1));
      pick = $urandom_range(9);
      if (!rq.durable) rq.sequence_req = '0;
      else if (pick == 0) rq.sequence_req = 32'd1;
      else if (pick == 1) rq.sequence_req = 32'hFFFF_FFFF;
      else rq.sequence_req = $urandom | 32'd1 << $urandom_range(31);
      if ($urandom_range(99) < 8) begin
         rq.type_present = 1'($urandom_range(1));
         rq.sequence_req = $urandom_range(1) ? $urandom : 32'd0;
      end
      pick = $urandom_range(99);
      if (pick < 3) rq.opcode = OP_UNUSED;
      else if (pick < 3 + push_weight) rq.opcode = OP_PUSH;
      else if (pick < 15 + push_weight) rq.opcode = OP_REQUEUE;
      else rq.opcode = OP_POP;
      return rq;
   endfunction

   task automatic queue_request(logic [1:0] op, logic typ, logic dur, logic [31:0] seq,
                                logic [31:0] pay);
      req_type rq;
      rq.opcode = op;
      rq.type_present = typ;
      rq.durable = dur;
      rq.sequence_req = seq;
      rq.payload = pay;
      pending.insert(pending.size(), rq);
   endtask

   // Wait until every request has been taken and answered, then let the block settle.
   task automatic wait_idle();
      do @(negedge clock); while (pending.size() != 0 || expected.size() != 0 || start);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      model_capacity = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Stimulus: a directed sequence at capacity two, then random phases.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_capacity(5'd2);
      queue_request(OP_POP, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_PUSH, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF);
      queue_request(OP_PUSH, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0);
      queue_request(OP_PUSH, 1'b1, 1'b0, 32'd0, 32'd1);
      queue_request(OP_PUSH, 1'b1, 1'b1, 32'd1, 32'd2);
      queue_request(OP_PUSH, 1'b1, 1'b1, 32'd2, 32'd3);
      queue_request(OP_PUSH, 1'b0, 1'b1, 32'd5, 32'd4);
      queue_request(OP_PUSH, 1'b1, 1'b1, 32'd0, 32'd5);
      queue_request(OP_PUSH, 1'b1, 1'b0, 32'd7, 32'd6);
      queue_request(OP_REQUEUE, 1'b0, 1'b0, 32'd0, 32'd7);
      queue_request(OP_REQUEUE, 1'b1, 1'b0, 32'd0, 32'hA);
      queue_request(OP_REQUEUE, 1'b1, 1'b1, 32'd9, 32'hB);
      queue_request(OP_UNUSED, 1'b1, 1'b1, 32'd3, 32'hC);
      queue_request(OP_PUSH, 1'b1, 1'b0, 32'd0, 32'hD);
      queue_request(OP_PUSH, 1'b1, 1'b1, 32'h8000_0000, 32'hE);
      repeat (4) queue_request(OP_POP, 1'b0, 1'b0, 32'd0, 32'd0);
      queue_request(OP_REQUEUE, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_POP, 1'b1, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
      foreach (PHASE_CAPS[p]) begin
         wait_idle();
         write_capacity(PHASE_CAPS[p]);
         repeat (RANDOM_PER_PHASE) begin
            pending.insert(pending.size(), random_request($urandom_range(30, 65)));
         end
      end
      wait_idle();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected.insert(expected.size(), mailbox_step(req_data));
         if (start && busy) begin
            // Hold the request until the block takes it.
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (pending.size() != 0) begin
            start <= 1'b1;
            req_data <= pending[0];
            pending.delete(0);
            if (burst_left > 1) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Response monitor: each strobe is matched against the oldest expected response.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, got %p", $time, rsp_data);
         end else begin
            oldest = expected[0];
            expected.delete(0);
            check_field("status", 32'(oldest.status), 32'(rsp_data.status));
            check_field("item_valid", 32'(oldest.item_valid), 32'(rsp_data.item_valid));
            check_field("item_durable", 32'(oldest.item_durable),
                        32'(rsp_data.item_durable));
            check_field("item_sequence", oldest.item_sequence, rsp_data.item_sequence);
            check_field("item_payload", oldest.item_payload, rsp_data.item_payload);
            check_field("fill_level", 32'(oldest.fill_level), 32'(rsp_data.fill_level));
            check_field("dropped_total", oldest.dropped_ephemeral_total,
                        rsp_data.dropped_ephemeral_total);
            check_field("rejected_total", oldest.rejected_durable_total,
                        rsp_data.rejected_durable_total);
         end
      end
   end

   // Watchdog: too long without any request or response taken ends the run.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
